// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check on the cycle after the antecedent, disabled while reset is asserted
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/gse_pkg.sv =====
// Shared types and constants of the GSE packet extractor.
// No dependencies; used by every module of the block.
package gse_pkg;

	// Frame and packet format
	localparam int MAX_FRAME_BYTES = 65535;
	localparam int BB_HEADER       = 10;
	localparam int SMALL_LIMIT     = 12;

	// Width of the running sums and of their result ports
	localparam int TOTAL_WIDTH = 48;
	localparam int OUT_TOTAL_W = 48;

	// Depth of the step queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Byte classes
	localparam logic [2:0] CLS_HEADER = 3'd0;
	localparam logic [2:0] CLS_PACKET = 3'd1;
	localparam logic [2:0] CLS_PAD    = 3'd2;
	localparam logic [2:0] CLS_DROP   = 3'd3;
	localparam logic [2:0] CLS_SMALL  = 3'd4;

	// One result item without the totals
	typedef struct packed {
		logic [7:0] data;
		logic       fwd;
		logic       first;
		logic       last;
		logic [2:0] cls;
	} res_t;

	// Running totals after a step
	typedef struct packed {
		logic [31:0]            frames;
		logic [31:0]            packets;
		logic [TOTAL_WIDTH-1:0] length;
		logic [TOTAL_WIDTH-1:0] header;
		logic [TOTAL_WIDTH-1:0] payload;
		logic [TOTAL_WIDTH-1:0] padding;
	} totals_t;

	// Everything one accepted byte causes: one or two results and the totals
	typedef struct packed {
		res_t    r0;
		res_t    r1;
		logic    two;
		totals_t tot;
	} step_t;

	function automatic res_t mk_res(logic [7:0] data, logic fwd, logic first,
			logic last, logic [2:0] cls);
		res_t r;
		r.data  = data;
		r.fwd   = fwd;
		r.first = first;
		r.last  = last;
		r.cls   = cls;
		return r;
	endfunction

endpackage

// ===== src/gse_packet_extractor.sv =====
// GSE packet extractor. Takes one baseband frame byte per clock while full is
// low and gives one result per clock while empty is low and pop is high. Most
// bytes cause one result; the second byte of a packet (and a frame start that
// cuts off a held packet byte) causes two, and the first byte of a packet
// causes none, so the result side sets the sustained rate at one result per
// cycle. A byte's record is stored in the step queue at the edge that accepts
// it, and the result-side output register then loads it from the queue. The
// step queue holds four step records, one per byte that gives results, so the
// input keeps flowing while the result side stalls, until the queue is full.
// Depends on gse_pkg, gse_front, gse_queue and gse_back.
module gse_packet_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               frame_first,
	input  logic [15:0]        frame_bytes,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               forward,
	output logic               packet_first,
	output logic               packet_last,
	output logic [2:0]         byte_class,
	output logic               run_last,
	output logic [31:0]        frames_total,
	output logic [31:0]        packets_total,
	output logic signed [47:0] length_total,
	output logic [47:0]        header_total,
	output logic signed [47:0] payload_total,
	output logic [47:0]        padding_total
);

	logic             accept;
	logic             wr_en;
	gse_pkg::step_t   wr_step;
	logic             q_pop;
	logic             q_empty;
	gse_pkg::step_t   q_step;
	gse_pkg::res_t    res;
	gse_pkg::totals_t tot;
	logic [63:0]      ext_length, ext_header, ext_payload, ext_padding;

	assign accept = push && !full;

	gse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.frame_first (frame_first),
		.frame_bytes (frame_bytes),
		.wr_en       (wr_en),
		.wr_step     (wr_step)
	);

	gse_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_step (wr_step),
		.full    (full),
		.rd_en   (q_pop),
		.rd_step (q_step),
		.empty   (q_empty)
	);

	gse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_step   (q_step),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res),
		.run_last (run_last),
		.tot      (tot)
	);

	// Drive result fields
	assign out_byte      = res.data;
	assign forward       = res.fwd;
	assign packet_first  = res.first;
	assign packet_last   = res.last;
	assign byte_class    = res.cls;
	assign frames_total  = tot.frames;
	assign packets_total = tot.packets;

	// Fit the sums to the result port width
	assign ext_length  = 64'(tot.length);
	assign ext_header  = 64'(tot.header);
	assign ext_payload = 64'(tot.payload);
	assign ext_padding = 64'(tot.padding);
	assign length_total  = signed'(ext_length[gse_pkg::OUT_TOTAL_W-1:0]);
	assign header_total  = ext_header[gse_pkg::OUT_TOTAL_W-1:0];
	assign payload_total = signed'(ext_payload[gse_pkg::OUT_TOTAL_W-1:0]);
	assign padding_total = ext_padding[gse_pkg::OUT_TOTAL_W-1:0];

endmodule

// ===== src/gse_front.sv =====
// Front part of the GSE packet extractor: parses one frame byte per cycle while
// accept is high and writes a step record for the back part. Depends on gse_pkg.
module gse_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 frame_first,
	input  logic [15:0]          frame_bytes,
	output logic                 wr_en,
	output gse_pkg::step_t       wr_step
);

	typedef enum logic [2:0] {
		PH_HDR,
		PH_IDLE,
		PH_SECOND,
		PH_BODY,
		PH_PAD,
		PH_DROP,
		PH_SMALL
	} phase_t;

	localparam int TW = gse_pkg::TOTAL_WIDTH;

	phase_t      phase_q, nxt_phase;
	logic [15:0] pos_q, nxt_pos;
	logic [15:0] flen_q, nxt_flen;
	logic [7:0]  held_q, nxt_held;
	logic [11:0] rem_q, nxt_rem;
	gse_pkg::totals_t tot_q, nxt_tot;

	logic [15:0] len_sat;
	logic [16:0] len_delta;
	logic [15:0] p_eff;
	logic [11:0] dl;
	logic [3:0]  hlen;
	logic [13:0] pay_delta;
	logic [17:0] pkt_end;
	logic [11:0] rem_dec;
	logic        early;
	logic [1:0]  m_n;
	gse_pkg::res_t m0, m1;

	// Header length from the start, end and label-type bits
	function automatic logic [3:0] header_length(logic [7:0] b1);
		logic [3:0] label;
		case (b1[5:4])
			2'b00:   label = 4'd6;
			2'b01:   label = 4'd3;
			default: label = 4'd0;
		endcase
		if (b1[7] && b1[6]) begin
			return 4'd4 + label;
		end else if (b1[7]) begin
			return 4'd7 + label;
		end else if (b1[6]) begin
			return 4'd7;
		end
		return 4'd3;
	endfunction

	assign len_sat = (32'(frame_bytes) > gse_pkg::MAX_FRAME_BYTES) ?
		16'(gse_pkg::MAX_FRAME_BYTES) : frame_bytes;
	assign len_delta = {1'b0, len_sat} - 17'(gse_pkg::BB_HEADER);
	assign dl        = {held_q[3:0], data_byte};
	assign hlen      = header_length(held_q);
	assign pay_delta = {2'b00, dl} + 14'd2 - {10'd0, hlen};
	assign rem_dec   = (rem_q != 12'd0) ? rem_q - 12'd1 : 12'd0;
	assign early     = frame_first && (phase_q == PH_SECOND);

	// Parse one byte: next state, results and totals
	always_comb begin
		nxt_phase = phase_q;
		nxt_flen  = flen_q;
		nxt_held  = held_q;
		nxt_rem   = rem_q;
		nxt_tot   = tot_q;
		m_n       = 2'd0;
		m0        = gse_pkg::mk_res(data_byte, 1'b0, 1'b0, 1'b0, gse_pkg::CLS_DROP);
		m1        = m0;
		pkt_end   = 18'd0;

		// Start a new frame: latch length, count it unless it is small
		if (frame_first) begin
			nxt_flen = len_sat;
			nxt_tot.length = tot_q.length + {{(TW-17){len_delta[16]}}, len_delta};
			if (32'(len_sat) <= gse_pkg::SMALL_LIMIT) begin
				nxt_phase = PH_SMALL;
			end else begin
				nxt_phase = PH_HDR;
				nxt_tot.frames = tot_q.frames + 32'd1;
			end
		end
		p_eff = frame_first ? 16'd0 : pos_q;

		if (p_eff >= nxt_flen) begin
			m_n = 2'd1;
		end else begin
			case (nxt_phase)
				PH_HDR: begin
					m_n = 2'd1;
					m0.cls = gse_pkg::CLS_HEADER;
					if (32'(p_eff) >= gse_pkg::BB_HEADER - 1) begin
						nxt_phase = PH_IDLE;
					end
				end
				PH_IDLE: begin
					if (data_byte[7:4] == 4'd0) begin
						m_n = 2'd1;
						m0.cls = gse_pkg::CLS_PAD;
						nxt_tot.padding = tot_q.padding + TW'(nxt_flen - p_eff);
						nxt_phase = PH_PAD;
					end else if (17'(p_eff) + 17'd1 >= 17'(nxt_flen)) begin
						m_n = 2'd1;
						nxt_phase = PH_DROP;
					end else begin
						nxt_held = data_byte;
						nxt_phase = PH_SECOND;
					end
				end
				PH_SECOND: begin
					m_n = 2'd2;
					nxt_tot.header  = tot_q.header + TW'(hlen);
					nxt_tot.payload = tot_q.payload +
						{{(TW-14){pay_delta[13]}}, pay_delta};
					pkt_end = 18'(p_eff) + 18'd1 + 18'(dl);
					if (pkt_end > 18'(nxt_flen)) begin
						m0 = gse_pkg::mk_res(held_q, 1'b0, 1'b0, 1'b0, gse_pkg::CLS_DROP);
						nxt_phase = PH_DROP;
					end else begin
						nxt_tot.packets = tot_q.packets + 32'd1;
						m0 = gse_pkg::mk_res(held_q, 1'b1, 1'b1, 1'b0, gse_pkg::CLS_PACKET);
						m1 = gse_pkg::mk_res(data_byte, 1'b1, 1'b0, dl == 12'd0,
							gse_pkg::CLS_PACKET);
						nxt_rem = dl;
						nxt_phase = (dl == 12'd0) ? PH_IDLE : PH_BODY;
					end
				end
				PH_BODY: begin
					m_n = 2'd1;
					m0 = gse_pkg::mk_res(data_byte, 1'b1, 1'b0, rem_dec == 12'd0,
						gse_pkg::CLS_PACKET);
					nxt_rem = rem_dec;
					if (rem_dec == 12'd0) begin
						nxt_phase = PH_IDLE;
					end
				end
				PH_PAD: begin
					m_n = 2'd1;
					m0.cls = gse_pkg::CLS_PAD;
				end
				PH_SMALL: begin
					m_n = 2'd1;
					m0.cls = gse_pkg::CLS_SMALL;
				end
				default: begin
					m_n = 2'd1;
				end
			endcase
		end

		// Saturate the byte position
		nxt_pos = (p_eff != 16'hFFFF) ? p_eff + 16'd1 : p_eff;
	end

	// On a frame start that cuts off a held byte, put the dropped held byte ahead of this byte's results
	always_comb begin
		wr_step.tot = nxt_tot;
		if (early) begin
			wr_step.r0  = gse_pkg::mk_res(held_q, 1'b0, 1'b0, 1'b0, gse_pkg::CLS_DROP);
			wr_step.r1  = m0;
			wr_step.two = (m_n != 2'd0);
			wr_en       = accept;
		end else begin
			wr_step.r0  = m0;
			wr_step.r1  = m1;
			wr_step.two = (m_n == 2'd2);
			wr_en       = accept && (m_n != 2'd0);
		end
	end

	// Hold parse state; advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= 16'd0;
			flen_q  <= 16'd0;
			held_q  <= 8'd0;
			rem_q   <= 12'd0;
			tot_q   <= '0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			pos_q   <= nxt_pos;
			flen_q  <= nxt_flen;
			held_q  <= nxt_held;
			rem_q   <= nxt_rem;
			tot_q   <= nxt_tot;
		end
	end

endmodule

// ===== src/gse_queue.sv =====
// Short queue of step records between the front and back parts.
// Depends on gse_pkg for the record type and depth.
module gse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  gse_pkg::step_t wr_step,
	output logic           full,
	input  logic           rd_en,
	output gse_pkg::step_t rd_step,
	output logic           empty
);

	gse_pkg::step_t              entry_q [gse_pkg::QUEUE_DEPTH];
	logic [gse_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [gse_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [gse_pkg::QPTR_W:0]    count_q;

	assign full    = (32'(count_q) == gse_pkg::QUEUE_DEPTH);
	assign empty   = (count_q == '0);
	assign rd_step = entry_q[rd_ptr_q];

	// Store records
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_step;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/gse_back.sv =====
// Back part of the GSE packet extractor: takes step records from the queue and
// presents their results one per cycle while pop is high. Depends on gse_pkg.
module gse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  gse_pkg::step_t q_step,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output gse_pkg::res_t  res,
	output logic           run_last,
	output gse_pkg::totals_t tot
);

	gse_pkg::step_t cur_q;
	logic           valid_q;
	logic           idx_q;
	logic           take;

	assign empty    = !valid_q;
	assign res      = idx_q ? cur_q.r1 : cur_q.r0;
	assign run_last = idx_q || !cur_q.two;
	assign tot      = cur_q.tot;
	assign take     = !valid_q || (pop && run_last);
	assign q_pop    = take && !q_empty;

	// Load the next record when the current one is done or none is held
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_step;
		end
	end

	// Step through the results of the current record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (take) begin
			valid_q <= !q_empty;
			idx_q   <= 1'b0;
		end else if (pop) begin
			idx_q <= 1'b1;
		end
	end

endmodule

// ===== src/gse_checker.sv =====
// Port-level checks of the GSE packet extractor, bound to its top level.
// Depends on gse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic               forward,
	input logic               packet_first,
	input logic               packet_last,
	input logic [2:0]         byte_class,
	input logic               run_last,
	input logic [31:0]        frames_total,
	input logic [31:0]        packets_total
);

	// Forwarded items are packet bytes
	`CHK_IMPL(a_fwd_class, !empty && forward, byte_class == gse_pkg::CLS_PACKET, "forwarded item not packet class")

	// A packet's first item is forwarded and always has its second item behind it
	`CHK_IMPL(a_first_pair, !empty && packet_first, forward && !run_last && !packet_last, "bad packet first item")

	// The second item of a byte's results follows right away
	`CHK_NEXT(a_pair_ready, pop && !empty && !run_last, !empty, "second result of a byte missing")

	// Totals agree across the results of one byte
	`CHK_NEXT(a_pair_totals, pop && !empty && !run_last, $stable(frames_total) && $stable(packets_total), "totals changed within one byte")

endmodule

bind gse_packet_extractor gse_checker u_checker (.*);
